// ===== sv/lgs_pkg.sv =====
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 64;

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);

  localparam int CELL_TOTAL = GRID_ROWS * GRID_COLS;
  localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
  localparam int COUNT_MAX  = 4095;

  // field widths on the channels
  localparam int CMD_W       = 2;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 6;
  localparam int REPEAT_W    = 12;

  // B3/S23
  localparam int BIRTH_N   = 3;
  localparam int SURVIVE_N = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

endpackage

// ===== sv/lgs_if.sv =====
`timescale 1ns / 1ps

interface lgs_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [lgs_pkg::CMD_W-1:0]           command;
  logic [lgs_pkg::ROW_FIELD_W-1:0]     row;
  logic [lgs_pkg::COL_FIELD_W-1:0]     col;
  logic                                value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface lgs_res_if;
  logic                                valid;
  logic                                ready;
  logic                                cell_value;
  logic                                all_dead;
  logic [lgs_pkg::REPEAT_W-1:0]        repeat_count;
  logic                                repeat_all;

  modport source (output valid, cell_value, all_dead, repeat_count, repeat_all, input ready);
  modport sink   (input valid, cell_value, all_dead, repeat_count, repeat_all, output ready);
endinterface

// ===== sv/lgs_ram.sv =====
`timescale 1ns / 1ps

module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/life_generation_step.sv =====
`timescale 1ns / 1ps

// channel | dir | beat payload
// cmd     | in  | command, row, col, value
// res     | out | cell_value, all_dead, repeat_count, repeat_all
//
// Grids are stored one row per RAM word; one neighbour/rule unit walks the cells.
// Write/read pass through S_RMW and S_DONE to the result. A step walks one cell
// per cycle, plus a row fetch and writeback for each row, then goes to S_DONE.
// Reset clears per-row valid flags at once; no clearing pass.
// cmd.ready is high only while idle; a result waiting on res does not stop the
// next accept, but the following result waits until res is free.

module life_generation_step (
  input  logic      clk,
  input  logic      rst,
  lgs_cmd_if.sink   cmd,
  lgs_res_if.source res
);

  localparam int ROWS  = lgs_pkg::GRID_ROWS;
  localparam int COLS  = lgs_pkg::GRID_COLS;
  localparam int RW    = lgs_pkg::ROW_W;
  localparam int CW    = lgs_pkg::COL_W;
  localparam int NW    = lgs_pkg::CNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RMW     = 3'd1;
  localparam logic [2:0] S_ST1     = 3'd2;
  localparam logic [2:0] S_ST2     = 3'd3;
  localparam logic [2:0] S_FETCH   = 3'd4;
  localparam logic [2:0] S_CELL    = 3'd5;
  localparam logic [2:0] S_ROW_END = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state;

  // latched command
  logic [lgs_pkg::CMD_W-1:0] lat_cmd;
  logic [RW-1:0]             lat_row;
  logic [CW-1:0]             lat_col;
  logic                      lat_value;

  // step datapath
  logic [RW-1:0]   r;
  logic [CW-1:0]   c;
  logic [COLS-1:0] above, mid, below, row0, past_row, new_row;
  logic            below_from_row0;
  logic [NW-1:0]   count;
  logic            any_live;

  // pending result
  logic                         p_cell, p_dead, p_all;
  logic [lgs_pkg::REPEAT_W-1:0] p_count;

  // output register
  logic                         o_valid, o_cell, o_dead, o_all;
  logic [lgs_pkg::REPEAT_W-1:0] o_count;

  // RAM ports
  logic            cur_we, past_we;
  logic [RW-1:0]   cur_waddr, past_waddr, cur_raddr, past_raddr;
  logic [COLS-1:0] cur_wdata, past_wdata, cur_rdata, past_rdata;
  logic [COLS-1:0] cur_data, past_data, rmw_row;
  logic [ROWS-1:0] cur_valid, past_valid;
  logic            cur_rvalid, past_rvalid;

  logic          accept, in_grid, out_free;
  logic [RW-1:0] in_row_addr;
  logic [CW-1:0] in_col_addr;
  logic [CW-1:0] cm, cp;
  logic [3:0]    nsum;
  logic          nv, match;
  logic [31:0]   cnt_wide;

  lgs_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_cur (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rdata)
  );

  lgs_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_past (
    .clk(clk), .we(past_we), .waddr(past_waddr), .wdata(past_wdata),
    .raddr(past_raddr), .rdata(past_rdata)
  );

  assign accept      = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == S_IDLE);
  assign in_grid     = (9'(cmd.row) < 9'(ROWS)) && (9'(cmd.col) < 9'(COLS));
  assign in_row_addr = RW'(cmd.row);
  assign in_col_addr = CW'(cmd.col);
  assign out_free    = !o_valid || res.ready;

  // rows never written read as dead
  assign cur_data  = cur_rvalid  ? cur_rdata  : '0;
  assign past_data = past_rvalid ? past_rdata : '0;

  always_comb begin
    rmw_row          = cur_data;
    rmw_row[lat_col] = lat_value;
  end

  // neighbour and rule unit, one cell per cycle
  assign cm = (c == '0) ? CW'(COLS - 1) : c - CW'(1);
  assign cp = (c == CW'(COLS - 1)) ? '0 : c + CW'(1);
  assign nsum = 4'(above[cm]) + 4'(above[c]) + 4'(above[cp]) +
                4'(mid[cm])                  + 4'(mid[cp])   +
                4'(below[cm]) + 4'(below[c]) + 4'(below[cp]);
  assign nv    = (nsum == 4'(lgs_pkg::BIRTH_N)) ||
                 (mid[c] && (nsum == 4'(lgs_pkg::SURVIVE_N)));
  assign match = (past_row[c] == mid[c]) || (past_row[c] == nv);

  assign cnt_wide = 32'(count);

  always_comb begin
    cur_raddr  = '0;
    past_raddr = '0;
    cur_we     = 1'b0;
    cur_waddr  = r;
    cur_wdata  = new_row;
    past_we    = 1'b0;
    past_waddr = r;
    past_wdata = mid;
    unique case (state)
      S_IDLE: begin
        if (cmd.command == lgs_pkg::CMD_STEP) begin
          cur_raddr = RW'(ROWS - 1);
        end else begin
          cur_raddr = in_row_addr;
        end
      end
      S_RMW: begin
        cur_we    = (lat_cmd == lgs_pkg::CMD_WRITE);
        cur_waddr = lat_row;
        cur_wdata = rmw_row;
      end
      S_ST1: begin
        cur_raddr = '0;
      end
      S_ST2: begin
        cur_raddr  = RW'(1);
        past_raddr = '0;
      end
      S_ROW_END: begin
        cur_we     = 1'b1;
        past_we    = 1'b1;
        cur_raddr  = (r == RW'(ROWS - 2)) ? '0 : r + RW'(2);
        past_raddr = (r == RW'(ROWS - 1)) ? '0 : r + RW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_rvalid  <= cur_valid[cur_raddr];
    past_rvalid <= past_valid[past_raddr];
    if (rst) begin
      cur_valid  <= '0;
      past_valid <= '0;
    end else begin
      if (cur_we) begin
        cur_valid[cur_waddr] <= 1'b1;
      end
      if (past_we) begin
        past_valid[past_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lat_cmd   <= cmd.command;
            lat_row   <= in_row_addr;
            lat_col   <= in_col_addr;
            lat_value <= cmd.value;
            p_cell    <= 1'b0;
            p_dead    <= 1'b0;
            p_count   <= '0;
            p_all     <= 1'b0;
            if (cmd.command == lgs_pkg::CMD_STEP) begin
              state <= S_ST1;
            end else if (in_grid && (cmd.command == lgs_pkg::CMD_WRITE ||
                                     cmd.command == lgs_pkg::CMD_READ)) begin
              state <= S_RMW;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RMW: begin
          if (lat_cmd == lgs_pkg::CMD_READ) begin
            p_cell <= cur_data[lat_col];
          end
          state <= S_DONE;
        end
        S_ST1: begin
          above <= cur_data;
          state <= S_ST2;
        end
        S_ST2: begin
          mid             <= cur_data;
          row0            <= cur_data;
          below_from_row0 <= 1'b0;
          r               <= '0;
          c               <= '0;
          count           <= '0;
          any_live        <= 1'b0;
          state           <= S_FETCH;
        end
        S_FETCH: begin
          // row 0 has been overwritten by now, so the last row uses the saved copy
          below    <= below_from_row0 ? row0 : cur_data;
          past_row <= past_data;
          state    <= S_CELL;
        end
        S_CELL: begin
          new_row[c] <= nv;
          if (nv) begin
            any_live <= 1'b1;
          end
          if (match) begin
            count <= count + NW'(1);
          end
          if (c == CW'(COLS - 1)) begin
            c     <= '0;
            state <= S_ROW_END;
          end else begin
            c <= c + CW'(1);
          end
        end
        S_ROW_END: begin
          above <= mid;
          mid   <= below;
          if (r == RW'(ROWS - 1)) begin
            p_dead  <= !any_live;
            p_count <= (cnt_wide > 32'(lgs_pkg::COUNT_MAX)) ?
                       lgs_pkg::REPEAT_W'(lgs_pkg::COUNT_MAX) :
                       cnt_wide[lgs_pkg::REPEAT_W-1:0];
            p_all   <= (cnt_wide == 32'(lgs_pkg::CELL_TOTAL));
            state   <= S_DONE;
          end else begin
            below_from_row0 <= (r == RW'(ROWS - 2));
            r               <= r + RW'(1);
            state           <= S_FETCH;
          end
        end
        S_DONE: begin
          if (out_free) begin
            o_cell  <= p_cell;
            o_dead  <= p_dead;
            o_count <= p_count;
            o_all   <= p_all;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid        = o_valid;
  assign res.cell_value   = o_cell;
  assign res.all_dead     = o_dead;
  assign res.repeat_count = o_count;
  assign res.repeat_all   = o_all;

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.command == lgs_pkg::CMD_STEP) |=> !cmd.ready)
    else $error("ready high right after a step beat");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL) |-> (9'(c) < 9'(COLS)))
    else $error("column counter out of grid");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_CELL || state == S_ROW_END) |-> (9'(r) < 9'(ROWS)))
    else $error("row counter out of grid");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.cell_value |-> !res.all_dead && !res.repeat_all &&
                                    (res.repeat_count == '0))
    else $error("read beat carries step fields");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.repeat_all |->
      (res.repeat_count == ((lgs_pkg::CELL_TOTAL > lgs_pkg::COUNT_MAX) ?
        lgs_pkg::REPEAT_W'(lgs_pkg::COUNT_MAX) : lgs_pkg::REPEAT_W'(lgs_pkg::CELL_TOTAL))))
    else $error("repeat_all without full count");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int GRID_ROWS   = lgs_pkg::GRID_ROWS;
  localparam int GRID_COLS   = lgs_pkg::GRID_COLS;
  localparam int CELL_TOTAL  = lgs_pkg::CELL_TOTAL;
  localparam int COUNT_MAX   = lgs_pkg::COUNT_MAX;
  localparam int CMD_W       = lgs_pkg::CMD_W;
  localparam int ROW_FIELD_W = lgs_pkg::ROW_FIELD_W;
  localparam int COL_FIELD_W = lgs_pkg::COL_FIELD_W;
  localparam int REPEAT_W    = lgs_pkg::REPEAT_W;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 12000;  // one full step plus the longest sink hold, several times
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 262;

  typedef struct packed {
    logic                cell_value;
    logic                all_dead;
    logic [REPEAT_W-1:0] repeat_count;
    logic                repeat_all;
  } life_result_t;

  logic clk;
  logic rst;

  lgs_cmd_if cmd_ch();
  lgs_res_if res_ch();

  life_generation_step u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // shadow copy of the two grids
  bit live_now  [GRID_ROWS][GRID_COLS];
  bit live_prev [GRID_ROWS][GRID_COLS];

  life_result_t pending_results[$];

  int  error_count;
  int  items_sent;
  int  results_seen;
  int  op_tally [4];
  bit  idle_on;
  int  hold_requests;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic life_result_t apply_command(input logic [CMD_W-1:0] op,
                                                 input logic [ROW_FIELD_W-1:0] r,
                                                 input logic [COL_FIELD_W-1:0] c,
                                                 input logic v);
    life_result_t outcome;
    bit born [GRID_ROWS][GRID_COLS];
    bit any_live;
    int same_cnt;
    int n;
    int rr, cc, dr, dc;
    outcome = '0;
    case (op)
      lgs_pkg::CMD_WRITE: begin
        if (r < GRID_ROWS && c < GRID_COLS) live_now[r][c] = v;
      end
      lgs_pkg::CMD_READ: begin
        if (r < GRID_ROWS && c < GRID_COLS) outcome.cell_value = live_now[r][c];
      end
      lgs_pkg::CMD_STEP: begin
        any_live = 1'b0;
        same_cnt = 0;
        for (rr = 0; rr < GRID_ROWS; rr++) begin
          for (cc = 0; cc < GRID_COLS; cc++) begin
            n = 0;
            for (dr = -1; dr <= 1; dr++) begin
              for (dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0)
                  n += live_now[(rr + GRID_ROWS + dr) % GRID_ROWS]
                               [(cc + GRID_COLS + dc) % GRID_COLS];
              end
            end
            born[rr][cc] = (n == lgs_pkg::BIRTH_N) ||
                           (live_now[rr][cc] && n == lgs_pkg::SURVIVE_N);
            if (born[rr][cc]) any_live = 1'b1;
          end
        end
        for (rr = 0; rr < GRID_ROWS; rr++) begin
          for (cc = 0; cc < GRID_COLS; cc++) begin
            if (live_prev[rr][cc] == live_now[rr][cc] || live_prev[rr][cc] == born[rr][cc])
              same_cnt++;
          end
        end
        outcome.all_dead     = !any_live;
        outcome.repeat_count = REPEAT_W'((same_cnt > COUNT_MAX) ? COUNT_MAX : same_cnt);
        outcome.repeat_all   = (same_cnt == CELL_TOTAL);
        live_prev = live_now;
        live_now  = born;
      end
      default: begin
      end
    endcase
    return outcome;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] op, input int r, input int c,
                           input logic v);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.command <= op;
    cmd_ch.row     <= r[ROW_FIELD_W-1:0];
    cmd_ch.col     <= c[COL_FIELD_W-1:0];
    cmd_ch.value   <= v;
    cmd_ch.valid   <= 1'b1;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pending_results.push_back(apply_command(op, r[ROW_FIELD_W-1:0],
                                            c[COL_FIELD_W-1:0], v));
    items_sent++;
    op_tally[op]++;
  endtask

  // drop a small pattern with its corner at (r0, c0); wraps at the edges
  task automatic place_shape(input int kind, input int r0, input int c0);
    int dr[$];
    int dc[$];
    case (kind)
      0:       begin dr = '{0, 1, 2, 2, 2}; dc = '{1, 2, 0, 1, 2}; end  // glider
      1:       begin dr = '{0, 0, 0};       dc = '{0, 1, 2};       end  // blinker
      2:       begin dr = '{0, 0, 1, 1};    dc = '{0, 1, 0, 1};    end  // block
      default: begin dr = '{0, 0, 1, 1, 2}; dc = '{1, 2, 0, 1, 1}; end  // r-pentomino
    endcase
    foreach (dr[i])
      send_item(lgs_pkg::CMD_WRITE, (r0 + dr[i]) % GRID_ROWS, (c0 + dc[i]) % GRID_COLS,
                1'b1);
  endtask

  task automatic test_reset_state();
    // empty grid: past equals current everywhere
    send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_READ, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_READ, GRID_ROWS - 1, GRID_COLS - 1, 1'b0);
  endtask

  task automatic test_cell_access();
    send_item(lgs_pkg::CMD_WRITE, 0, 0, 1'b1);
    send_item(lgs_pkg::CMD_WRITE, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);
    send_item(lgs_pkg::CMD_WRITE, 0, GRID_COLS - 1, 1'b1);
    send_item(lgs_pkg::CMD_WRITE, GRID_ROWS - 1, 0, 1'b1);
    send_item(lgs_pkg::CMD_READ, GRID_ROWS - 1, GRID_COLS - 1, 1'b0);
    send_item(lgs_pkg::CMD_READ, 0, GRID_COLS - 1, 1'b0);
    // unused opcode must leave the grid alone and return zeros
    send_item(CMD_UNUSED, GRID_ROWS - 1, GRID_COLS - 1, 1'b0);
    send_item(lgs_pkg::CMD_READ, GRID_ROWS - 1, GRID_COLS - 1, 1'b0);
  endtask

  task automatic test_wrap_patterns();
    // four corners form a block across the wrap: still life
    send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_READ, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_WRITE, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_WRITE, GRID_ROWS - 1, GRID_COLS - 1, 1'b0);
    send_item(lgs_pkg::CMD_WRITE, 0, GRID_COLS - 1, 1'b0);
    send_item(lgs_pkg::CMD_WRITE, GRID_ROWS - 1, 0, 1'b0);
    // blinker straddling the column wrap, period two
    place_shape(1, 0, GRID_COLS - 1);
    send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
    send_item(lgs_pkg::CMD_READ, GRID_ROWS - 1, 0, 1'b0);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0)
        send_item(lgs_pkg::CMD_WRITE, $urandom_range(0, GRID_ROWS - 1),
                  $urandom_range(0, GRID_COLS - 1), 1'($urandom_range(0, 1)));
      else
        send_item(lgs_pkg::CMD_READ, $urandom_range(0, GRID_ROWS - 1),
                  $urandom_range(0, GRID_COLS - 1), 1'b0);
    end
  endtask

  task automatic test_random_sequences();
    int stop_at;
    int kind;
    int rr, cc;
    int live_r[$];
    int live_c[$];
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // seed a pattern anywhere, then let it run
        place_shape($urandom_range(0, 3), $urandom_range(0, GRID_ROWS - 1),
                    $urandom_range(0, GRID_COLS - 1));
        repeat ($urandom_range(1, 3)) begin
          send_item(lgs_pkg::CMD_STEP, $urandom_range(0, 31), $urandom_range(0, 63),
                    1'($urandom_range(0, 1)));
          send_item(lgs_pkg::CMD_READ, $urandom_range(0, 31), $urandom_range(0, 63), 1'b0);
        end
      end else if (kind < 60) begin
        repeat ($urandom_range(4, 14))
          send_item(lgs_pkg::CMD_WRITE, $urandom_range(0, 31), $urandom_range(0, 63),
                    1'($urandom_range(0, 2) != 0));
        send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
      end else if (kind < 75) begin
        // if at most 48 cells live, kill them all so the next step comes out all dead
        live_r.delete();
        live_c.delete();
        for (rr = 0; rr < GRID_ROWS; rr++)
          for (cc = 0; cc < GRID_COLS; cc++)
            if (live_now[rr][cc]) begin
              live_r.push_back(rr);
              live_c.push_back(cc);
            end
        if (live_r.size() <= 48) begin
          foreach (live_r[i]) begin
            if ($urandom_range(0, 3) == 0)
              send_item(lgs_pkg::CMD_READ, live_r[i], live_c[i], 1'b0);
            send_item(lgs_pkg::CMD_WRITE, live_r[i], live_c[i], 1'b0);
          end
          send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
          send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
        end else begin
          send_item(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
        end
      end else begin
        // noise: any opcode, any field value
        repeat ($urandom_range(3, 10)) begin
          if ($urandom_range(0, 3) == 0)
            send_item(lgs_pkg::CMD_STEP, $urandom_range(0, 31), $urandom_range(0, 63),
                      1'($urandom_range(0, 1)));
          else
            send_item(2'($urandom_range(0, 1) ? CMD_UNUSED : $urandom_range(0, 1)),
                      $urandom_range(0, 31), $urandom_range(0, 63),
                      1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // result sink: random stalls, plus a long hold when a test asks for one
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    int stall_left;
    int roll;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (idle_on && roll < 20) stall_left = $urandom_range(1, 3);
        else if (idle_on && roll < 24) stall_left = $urandom_range(10, 40);
      end
    end
  end

  initial begin : result_check
    life_result_t got;
    life_result_t want;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.cell_value   = res_ch.cell_value;
        got.all_dead     = res_ch.all_dead;
        got.repeat_count = res_ch.repeat_count;
        got.repeat_all   = res_ch.repeat_all;
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: %p", got);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.cell_value !== want.cell_value) begin
            $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
            error_count++;
          end
          if (got.all_dead !== want.all_dead) begin
            $error("all_dead: expected %0d, got %0d", want.all_dead, got.all_dead);
            error_count++;
          end
          if (got.repeat_count !== want.repeat_count) begin
            $error("repeat_count: expected %0d, got %0d", want.repeat_count,
                   got.repeat_count);
            error_count++;
          end
          if (got.repeat_all !== want.repeat_all) begin
            $error("repeat_all: expected %0d, got %0d", want.repeat_all, got.repeat_all);
            error_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    error_count   = 0;
    items_sent    = 0;
    results_seen  = 0;
    idle_on       = 1'b0;
    hold_requests = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = lgs_pkg::CMD_WRITE;
    cmd_ch.row     = '0;
    cmd_ch.col     = '0;
    cmd_ch.value   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_cell_access();
    test_wrap_patterns();
    test_backpressure();
    test_random_sequences();

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Ran %0d commands (%0d steps, %0d reads, %0d writes, %0d unused opcode).",
             items_sent, op_tally[lgs_pkg::CMD_STEP], op_tally[lgs_pkg::CMD_READ],
             op_tally[lgs_pkg::CMD_WRITE], op_tally[CMD_UNUSED]);
    $display("Checked %0d results: wrap-around shapes, oscillators, wipe-outs, long hold.",
             results_seen);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
